FILE: design/sliding_window_mean_meter_top_assert.svh
`ifndef SLIDING_WINDOW_MEAN_METER_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MEAN_METER_TOP_ASSERT_SVH
// assertion helpers
`define SWMM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SWMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: design/swmm_pkg.sv
package swmm_pkg;
  localparam int Capacity = 128;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = IdxW + 1;
  localparam int SumW = 24;
  localparam int ValW = 17;
  localparam int StampW = 32;
  localparam logic [ValW-1:0] OneQ16 = ValW'(65536);
  localparam logic [15:0] WindowReset = 16'd1000;

  typedef struct packed {
    logic [StampW-1:0] now_ms;
    logic [ValW-1:0]   value;
  } item_t;

  typedef struct packed {
    logic [7:0]      sample_count;
    logic [ValW-1:0] mean_q16;
    logic            dropped_full;
  } result_t;
endpackage

FILE: design/swmm_front.sv
module swmm_front import swmm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [StampW-1:0]   now_ms,
  input  logic signed [23:0]  fraction_q16,
  output logic                q_valid,
  input  logic                q_take,
  output item_t               q_item
);
  localparam int Depth = 2;
  item_t buffer [Depth];
  logic wr_ptr, rd_ptr;
  logic [1:0] level;
  logic [ValW-1:0] clamped;
  logic do_push, do_pop;

  always_comb begin
    if (fraction_q16[23]) begin
      clamped = '0;
    end else if (fraction_q16[22:0] > 23'(OneQ16)) begin
      clamped = OneQ16;
    end else begin
      clamped = fraction_q16[ValW-1:0];
    end
  end

  assign full = (level == 2'd2);
  assign do_push = push && !full;
  assign q_valid = (level != 2'd0);
  assign do_pop = q_take && q_valid;
  assign q_item = buffer[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      buffer[wr_ptr] <= '{now_ms: now_ms, value: clamped};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      level <= level + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

FILE: design/swmm_back.sv
module swmm_back import swmm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_take,
  input  item_t             q_item,
  input  logic [15:0]       window_ms,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        sample_count,
  output logic [ValW-1:0]   mean_q16,
  output logic              dropped_full
);
  `include "sliding_window_mean_meter_top_assert.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_TEST = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state;
  logic [StampW-1:0] stamp_mem [Capacity];
  logic [ValW-1:0] value_mem [Capacity];
  logic [StampW-1:0] rd_stamp;
  logic [ValW-1:0] rd_value;
  logic [IdxW-1:0] head;
  logic [CntW-1:0] held;
  logic [SumW-1:0] sum;
  item_t cur;
  logic [StampW-1:0] cutoff;
  logic aging;
  logic dropped;
  logic [SumW-1:0] rem, quo;
  logic [4:0] bitpos;
  logic [SumW:0] trial;
  logic [IdxW-1:0] slot;
  logic out_valid;

  assign q_take = (state == S_IDLE) && q_valid;
  assign slot = head + held[IdxW-1:0];
  assign trial = {rem[SumW-2:0], sum[bitpos], 1'b0} >> 1;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    rd_stamp <= stamp_mem[head];
    rd_value <= value_mem[head];
    if (state == S_STORE) begin
      stamp_mem[slot] <= cur.now_ms;
      value_mem[slot] <= cur.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      held <= '0;
      sum <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            aging <= (q_item.now_ms >= {16'd0, window_ms});
            cutoff <= q_item.now_ms - {16'd0, window_ms};
            dropped <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: state <= S_TEST;
        S_TEST: begin
          if (held != '0 && ((aging && rd_stamp < cutoff) || held == CntW'(Capacity))) begin
            sum <= sum - SumW'(rd_value);
            head <= head + 1'b1;
            held <= held - 1'b1;
            if (aging && rd_stamp < cutoff) begin
              state <= S_READ;
            end else begin
              dropped <= 1'b1;
              state <= S_STORE;
            end
          end else begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          sum <= sum + SumW'(cur.value);
          held <= held + 1'b1;
          rem <= '0;
          quo <= '0;
          bitpos <= 5'(SumW - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (trial[SumW-1:0] >= SumW'(held)) begin
            rem <= trial[SumW-1:0] - SumW'(held);
            quo[bitpos] <= 1'b1;
          end else begin
            rem <= trial[SumW-1:0];
          end
          if (bitpos == 5'd0) state <= S_OUT;
          else bitpos <= bitpos - 1'b1;
        end
        S_OUT: begin
          if (!out_valid || pop) begin
            sample_count <= 8'(held);
            mean_q16 <= quo[ValW-1:0];
            dropped_full <= dropped;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SWMM_ASSERT_IMPL(a_held_cap, 1'b1, held <= CntW'(Capacity), "held count above capacity")
  `SWMM_ASSERT_NEXT(a_store_grows, state == S_STORE, held != '0, "store left ring empty")
  `SWMM_ASSERT_IMPL(a_out_nonzero, !empty, sample_count != 8'd0, "result with zero count")
endmodule

FILE: design/sliding_window_mean_meter_top.sv
// Each sample passes from the queue through read, test, store, divide and output states;
// each sample aged out of the window repeats read and test, and an overflow drop goes
// straight to store. Divide runs the 24-step serial divider. A new sample is taken
// only when the back end is idle; a result not taken holds it in its output state.
// A two-entry queue decouples input from processing; the result register holds one result.
// Reset (rst, synchronous, active high) empties the ring and queues; window returns to 1000.
module sliding_window_mean_meter_top import swmm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [StampW-1:0]   now_ms,
  input  logic signed [23:0]  fraction_q16,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          sample_count,
  output logic [ValW-1:0]     mean_q16,
  output logic                dropped_full,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  logic q_valid, q_take;
  item_t q_item;
  logic [15:0] window_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WindowReset;
    end else if (cfg_valid && cfg_ready) begin
      window_ms <= cfg_data;
    end
  end

  swmm_front u_front (
    .clk, .rst, .push, .full, .now_ms, .fraction_q16,
    .q_valid, .q_take, .q_item
  );

  swmm_back u_back (
    .clk, .rst, .q_valid, .q_take, .q_item, .window_ms,
    .empty, .pop, .sample_count, .mean_q16, .dropped_full
  );
endmodule

FILE: verif/swmm_checker.sv
module swmm_checker import swmm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [StampW-1:0]  now_ms,
  input  logic signed [23:0] fraction_q16,
  input  logic               empty,
  input  logic               pop,
  input  logic [7:0]         sample_count,
  input  logic [ValW-1:0]    mean_q16,
  input  logic               dropped_full,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [StampW-1:0] ring_stamp [Capacity];
  logic [ValW-1:0]   ring_value [Capacity];
  logic [IdxW-1:0]   oldest;
  logic [7:0]        held;
  logic [SumW-1:0]   total;
  logic [15:0]       window;
  result_t           mean_q [$];
  int                mismatches;

  function automatic void retire_oldest();
    total = total - SumW'(ring_value[oldest]);
    oldest = oldest + 1'b1;
    held = held - 1'b1;
  endfunction

  function automatic result_t take_sample(logic [StampW-1:0] stamp, logic [23:0] raw);
    result_t r;
    logic [ValW-1:0] v;
    logic [StampW-1:0] cutoff;
    logic [IdxW-1:0] slot;
    if (raw[23]) v = '0;
    else if (raw > 24'(OneQ16)) v = OneQ16;
    else v = raw[ValW-1:0];
    r.dropped_full = 1'b0;
    if (stamp >= StampW'(window)) begin
      cutoff = stamp - StampW'(window);
      while (held > 0 && ring_stamp[oldest] < cutoff) retire_oldest();
    end
    if (held >= 8'(Capacity)) begin
      retire_oldest();
      r.dropped_full = 1'b1;
    end
    slot = oldest + IdxW'(held);
    ring_stamp[slot] = stamp;
    ring_value[slot] = v;
    total = total + SumW'(v);
    held = held + 1'b1;
    r.sample_count = held;
    r.mean_q16 = (held == 0) ? '0 : ValW'(total / SumW'(held));
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      oldest = '0;
      held = '0;
      total = '0;
      window = WindowReset;
      mean_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) window = cfg_data;
      if (pop && !empty) begin
        if (mean_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result count=%0d mean=%0d drop=%0b",
                     $realtime, sample_count, mean_q16, dropped_full);
        end else begin
          want = mean_q.pop_front();
          if (want.sample_count !== sample_count || want.mean_q16 !== mean_q16 ||
              want.dropped_full !== dropped_full) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp count=%0d mean=%0d drop=%0b got %0d %0d %0b",
                       $realtime, want.sample_count, want.mean_q16, want.dropped_full,
                       sample_count, mean_q16, dropped_full);
          end
        end
      end
      if (push && !full) mean_q.push_back(take_sample(now_ms, fraction_q16));
    end
    fail_count <= mismatches;
    pending <= mean_q.size();
  end
endmodule

FILE: verif/tb_top.sv
module tb_top import swmm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 0;
  logic               rst = 1;
  logic               push = 0;
  logic               full;
  logic [StampW-1:0]  now_ms = '0;
  logic signed [23:0] fraction_q16 = '0;
  logic               empty;
  logic               pop = 0;
  logic [7:0]         sample_count;
  logic [ValW-1:0]    mean_q16;
  logic               dropped_full;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending;
  bit                 hold_req = 0;
  int                 idle_cycles = 0;
  logic [StampW-1:0]  clock_ms;

  localparam int IdleLimit = 20000;

  always #4 clk = ~clk;

  sliding_window_mean_meter_top uut (.*);

  swmm_checker chk (.*);

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int stall_mode;
    @(negedge rst);
    forever begin
      stall_mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk);
        if (hold_req) begin
          pop <= 0;
          repeat (600) @(posedge clk);
          hold_req = 0;
        end
        pop <= (stall_mode == 0) ? 1'b1 : ($urandom_range(0, stall_mode) == 0);
      end
    end
  end

  function automatic logic [23:0] pick_fraction();
    case ($urandom_range(0, 9))
      0: return {1'b1, 23'($urandom)};
      1: return 24'($urandom_range(65537, 24'h7FFFFF));
      2: return 24'(OneQ16);
      3: return 24'h0;
      4: return 24'h7FFFFF;
      5: return 24'h800000;
      6: return 24'hFFFFFF;
      default: return 24'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic send(logic [StampW-1:0] stamp, logic [23:0] raw);
    now_ms <= stamp;
    fraction_q16 <= raw;
    push <= 1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_window(logic [15:0] w);
    drain();
    cfg_data <= w;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  initial begin
    int step_max;
    int burst;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(0, 24'h0);
    send(0, 24'(OneQ16));
    send(0, 24'h800000);
    send(10, 24'h7FFFFF);
    send(500, 24'h010001);
    send(999, 24'hFFFFFF);
    send(1999, 24'h008000);
    send(100, 24'h000123);
    send(2500, 24'h00FFFF);
    set_window(16'd0);
    send(3000, 24'h001000);
    send(3000, 24'h002000);
    send(3001, 24'h003000);
    send(2999, 24'h004000);
    set_window(16'hFFFF);
    send(32'hFFFF_FFFF, 24'(OneQ16));
    send(32'hFFFF_FFFF, 24'h0);
    set_window(16'd1);
    send(32'h5555_5555, 24'h555555);
    send(32'hAAAA_AAAA, 24'hAAAAAA);

    for (int phase = 0; phase < 18; phase++) begin
      case (phase % 6)
        0: set_window(16'd0);
        1: set_window(16'd1);
        2: set_window(16'hFFFF);
        3: set_window(16'd1000);
        default: set_window(16'($urandom_range(1, 65535)));
      endcase
      step_max = (phase % 3 == 0) ? 2 : $urandom_range(1, 60);
      clock_ms = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 5000));
      for (int n = 0; n < 105; ) begin
        burst = $urandom_range(1, 30);
        if (phase == 4 && n == 0) hold_req = 1;
        for (int b = 0; b < burst && n < 105; b++, n++) begin
          if ($urandom_range(0, 40) == 0)
            clock_ms = clock_ms - 32'($urandom_range(0, 50));
          else if (clock_ms < 32'hFFFF_0000)
            clock_ms = clock_ms + 32'($urandom_range(0, step_max));
          send(clock_ms, pick_fraction());
        end
        push <= 0;
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 400)) @(posedge clk);
      end
    end

    drain();
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
